@@ sv/trle_pkg.sv @@
// Shared types and constants of the Targa run-length pixel decoder.
package trle_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLE   = 2'd1;

  // Pixel format codes
  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_555  = 2'd1;
  localparam logic [1:0] FMT_BGR  = 2'd2;
  localparam logic [1:0] FMT_BGRA = 2'd3;

  localparam logic [1:0] FMT_RESET = FMT_BGR;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] raw_value;
    logic [7:0]  repeat_res;
  } pixel_t;

endpackage

@@ sv/tga_rle_pixel_decoder_unit.sv @@
// Top level of the Targa image-body pixel decoder with run-length packet decoding.

// The block takes the image body of a Targa file one byte per transfer and
// returns one pixel transfer per completed pixel: 8-bit grey, 5-5-5, 24-bit
// BGR or 32-bit BGRA with the alpha byte dropped. With run-length decoding on,
// each packet opens with a header byte; a raw packet yields one pixel per
// stored pixel, a repeat packet yields a single pixel carrying its run length
// in repeat_res. Header bytes and bytes that do not complete a pixel yield
// nothing. Every byte is taken as it arrives, so the input sustains one byte per
// clock while it is not stalled; the limit is the update of the byte phase and
// packet counters. A two-entry output (result register plus skid register) keeps
// the input flowing while one result waits; the input stalls only when both
// entries are full. There is no clearing pass after reset. Write the
// configuration registers only while the block is idle; any write abandons a
// partly assembled pixel and any open packet.
module tga_rle_pixel_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [trle_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [trle_pkg::CFG_DATA_W-1:0]    cfg_data,
  // byte input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         byte_in,
  // pixel output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic [15:0]                        raw_value,
  output logic [7:0]                         repeat_res
);

  // Configuration
  logic [1:0] pixel_format;
  logic       rle_enable;

  // Stream state
  logic        expect_header, expect_header_next;
  logic [7:0]  raw_left, raw_left_next;
  logic        repeat_packet, repeat_packet_next;
  logic [7:0]  repeat_total, repeat_total_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [23:0] held_bytes, held_bytes_next;

  // Output register and skid register
  trle_pkg::pixel_t out_pix, skid_pix, new_pix;
  logic             skid_valid;

  logic       accept;
  logic       produce;
  logic       take;
  logic       is_header;
  logic       pixel_done;
  logic [7:0] b0, b1, b2;
  logic [7:0] raw_left_dec;
  logic [7:0] hdr_count;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  assign is_header  = rle_enable && expect_header;
  assign hdr_count  = {1'b0, byte_in[6:0]} + 8'd1;
  // The pixel completes on the byte whose phase reaches the last position.
  assign pixel_done = !is_header && (byte_phase == pixel_format);
  assign produce    = accept && pixel_done;

  // Bytes of the pixel with the current byte merged in at its phase.
  assign b0 = (byte_phase == 2'd0) ? byte_in : held_bytes[7:0];
  assign b1 = (byte_phase == 2'd1) ? byte_in : held_bytes[15:8];
  assign b2 = (byte_phase == 2'd2) ? byte_in : held_bytes[23:16];

  assign raw_left_dec = (raw_left != 8'd0) ? raw_left - 8'd1 : raw_left;

  // Assemble the pixel fields.
  always_comb begin
    new_pix = '0;
    case (pixel_format) inside
      trle_pkg::FMT_GREY: begin
        new_pix.red       = b0;
        new_pix.green     = b0;
        new_pix.blue      = b0;
        new_pix.raw_value = {8'd0, b0};
      end
      trle_pkg::FMT_555: begin
        // bit 15 is kept only in the raw word
        new_pix.red       = {3'd0, b1[6:2]};
        new_pix.green     = {3'd0, b1[1:0], b0[7:5]};
        new_pix.blue      = {3'd0, b0[4:0]};
        new_pix.raw_value = {b1, b0};
      end
      trle_pkg::FMT_BGR, trle_pkg::FMT_BGRA: begin
        new_pix.red       = b2;
        new_pix.green     = b1;
        new_pix.blue      = b0;
        new_pix.raw_value = 16'd0;
      end
      default: begin
        new_pix.raw_value = 16'd0;
      end
    endcase
    new_pix.repeat_res = (rle_enable && repeat_packet) ? repeat_total : 8'd1;
  end

  // Next stream state for an accepted byte.
  always_comb begin
    expect_header_next = expect_header;
    raw_left_next      = raw_left;
    repeat_packet_next = repeat_packet;
    repeat_total_next  = repeat_total;
    byte_phase_next    = byte_phase;
    held_bytes_next    = held_bytes;
    if (is_header) begin
      // open a packet
      expect_header_next = 1'b0;
      byte_phase_next    = 2'd0;
      if (byte_in[7]) begin
        repeat_packet_next = 1'b1;
        repeat_total_next  = hdr_count;
        raw_left_next      = 8'd0;
      end else begin
        repeat_packet_next = 1'b0;
        repeat_total_next  = 8'd1;
        raw_left_next      = hdr_count;
      end
    end else begin
      // the alpha byte is never stored
      held_bytes_next = {b2, b1, b0};
      if (!pixel_done) begin
        byte_phase_next = byte_phase + 2'd1;
      end else begin
        byte_phase_next = 2'd0;
        if (rle_enable) begin
          if (repeat_packet) begin
            expect_header_next = 1'b1;
          end else begin
            raw_left_next = raw_left_dec;
            if (raw_left_dec == 8'd0) begin
              expect_header_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // Configuration and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= trle_pkg::FMT_RESET;
      rle_enable    <= 1'b0;
      expect_header <= 1'b1;
      raw_left      <= 8'd0;
      repeat_packet <= 1'b0;
      repeat_total  <= 8'd1;
      byte_phase    <= 2'd0;
    end else if (cfg_we && (cfg_index == trle_pkg::REG_PIXEL_FORMAT ||
                            cfg_index == trle_pkg::REG_RLE_ENABLE)) begin
      if (cfg_index == trle_pkg::REG_PIXEL_FORMAT) begin
        pixel_format <= cfg_data[1:0];
      end else begin
        rle_enable <= cfg_data[0];
      end
      // drop any partial pixel and open packet
      expect_header <= 1'b1;
      raw_left      <= 8'd0;
      repeat_packet <= 1'b0;
      repeat_total  <= 8'd1;
      byte_phase    <= 2'd0;
    end else if (accept) begin
      expect_header <= expect_header_next;
      raw_left      <= raw_left_next;
      repeat_packet <= repeat_packet_next;
      repeat_total  <= repeat_total_next;
      byte_phase    <= byte_phase_next;
    end
  end

  // Held pixel bytes carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

  // Output and skid control: a new pixel goes straight to the output register
  // when it is free or being transferred, else it waits in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (produce) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (!out_valid || take) begin
        out_pix <= new_pix;
      end else begin
        skid_pix <= new_pix;
      end
    end else if (take && skid_valid) begin
      out_pix <= skid_pix;
    end
  end

  assign red        = out_pix.red;
  assign green      = out_pix.green;
  assign blue       = out_pix.blue;
  assign raw_value  = out_pix.raw_value;
  assign repeat_res = out_pix.repeat_res;

`ifndef SYNTHESIS
  // The skid register only holds a pixel behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // The skid register fills only when the output was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without an output stall");

  // The byte phase never runs past the last byte of a pixel.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    byte_phase <= pixel_format)
    else $error("byte phase beyond pixel length");

  // A raw-packet count and a repeat packet never coexist.
  a_packet_kind: assert property (@(posedge clk) disable iff (rst)
    (raw_left != 8'd0) |-> !repeat_packet)
    else $error("raw count left open in a repeat packet");
`endif

endmodule
